FILE: design/ufue_pkg.sv
// ----------------------------------------------------------------------------
// ufue_pkg
// Shared types, character constants and helpers for the UTF-16 form encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ufue_pkg;

    localparam int UnitWidth = 16;
    localparam int CharWidth = 7;
    localparam int MaxBytes  = 4;
    localparam int HalfWidth = 10;

    localparam logic [CharWidth-1:0] CharPlus    = 7'h2B;  // '+'
    localparam logic [CharWidth-1:0] CharPercent = 7'h25;  // '%'

    // How one UTF-8 byte is written out.
    typedef enum logic [1:0] {
        BYTE_PLUS,
        BYTE_PASS,
        BYTE_PCT
    } t_byte_kind;

    function automatic logic [CharWidth-1:0] hex_digit(input logic [3:0] nib);
        logic [CharWidth-1:0] ch;
        if (nib < 4'd10) begin
            ch = 7'h30 + {3'b000, nib};
        end else begin
            ch = 7'h37 + {3'b000, nib};
        end
        return ch;
    endfunction

    function automatic t_byte_kind byte_kind(input logic [7:0] b);
        t_byte_kind k;
        if (b == 8'h20) begin
            k = BYTE_PLUS;
        end else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A)
                     || (b >= 8'h61 && b <= 8'h7A) || b == 8'h2A || b == 8'h2D
                     || b == 8'h2E || b == 8'h5F) begin
            k = BYTE_PASS;
        end else begin
            k = BYTE_PCT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/utf16_form_url_encoder.sv
// ----------------------------------------------------------------------------
// utf16_form_url_encoder
// UTF-16 code units in, application/x-www-form-urlencoded UTF-8 text out.
// ----------------------------------------------------------------------------
// Each accepted code unit is decoded (surrogates paired) and encoded into one
// to four UTF-8 bytes in the accept cycle; the bytes wait in a job register
// and are written out one ASCII character per cycle when the output is not
// stalled: space as '+', letters, digits and *-._ as themselves, all else as
// '%' and two upper-case hex digits. An item therefore gives 0 to 12
// characters, three per escaped byte; the single output character per cycle
// sets the rate. A new unit is taken in the cycle the previous job emits its
// final character, so units that produce one character each flow at one per
// cycle while output is not stalled. NUL or a malformed surrogate sequence
// suppresses output until the unit marked last, which clears the decoder
// state. m_axis_tlast marks the final character caused by one input unit.
`default_nettype none

module utf16_form_url_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  wire logic        s_axis_tlast,   // last_unit
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [6:0] out_char, [7] zero
    output logic             m_axis_tlast    // last_char
);

    // decoder state
    logic [ufue_pkg::HalfWidth-1:0] r_high_half, n_high_half;
    logic                           r_high_pending, n_high_pending;
    logic                           r_halted, n_halted;

    // job register
    logic       r_job_valid;
    logic [7:0] r_bytes [ufue_pkg::MaxBytes];
    logic [1:0] r_last_idx;
    logic [1:0] r_byte_idx;
    logic [1:0] r_phase;

    // output register
    logic                           r_out_valid;
    logic [ufue_pkg::CharWidth-1:0] r_out_char;
    logic                           r_out_last;

    logic        in_acc;
    logic        emit;
    logic [20:0] cp;
    logic [7:0]  enc [ufue_pkg::MaxBytes];
    logic [1:0]  enc_last;
    logic        is_high, is_low;

    logic                           adv;
    logic [7:0]                     cur;
    ufue_pkg::t_byte_kind           kind;
    logic [ufue_pkg::CharWidth-1:0] ch;
    logic                           byte_done, job_done;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign is_high = (s_axis_tdata >= 16'hD800) && (s_axis_tdata <= 16'hDBFF);
    assign is_low  = (s_axis_tdata >= 16'hDC00) && (s_axis_tdata <= 16'hDFFF);

    // decode the unit and update the surrogate state
    always_comb begin
        n_high_half    = r_high_half;
        n_high_pending = r_high_pending;
        n_halted       = r_halted;
        emit           = 1'b0;
        cp             = {5'd0, s_axis_tdata};
        if (!r_halted) begin
            if (s_axis_tdata == 16'd0) begin
                n_halted       = 1'b1;
                n_high_pending = 1'b0;
            end else if (r_high_pending) begin
                if (is_low) begin
                    emit = 1'b1;
                    cp   = 21'h10000 + {1'b0, r_high_half, s_axis_tdata[9:0]};
                end else begin
                    n_halted = 1'b1;
                end
                n_high_pending = 1'b0;
            end else if (is_high) begin
                n_high_half    = s_axis_tdata[9:0];
                n_high_pending = 1'b1;
            end else if (is_low) begin
                n_halted = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end
        if (s_axis_tlast) begin
            n_high_half    = '0;
            n_high_pending = 1'b0;
            n_halted       = 1'b0;
        end
    end

    // UTF-8 encode
    always_comb begin
        enc[0] = 8'd0;
        enc[1] = 8'd0;
        enc[2] = 8'd0;
        enc[3] = 8'd0;
        if (cp < 21'h80) begin
            enc[0]   = cp[7:0];
            enc_last = 2'd0;
        end else if (cp < 21'h800) begin
            enc[0]   = {3'b110, cp[10:6]};
            enc[1]   = {2'b10, cp[5:0]};
            enc_last = 2'd1;
        end else if (cp < 21'h10000) begin
            enc[0]   = {4'b1110, cp[15:12]};
            enc[1]   = {2'b10, cp[11:6]};
            enc[2]   = {2'b10, cp[5:0]};
            enc_last = 2'd2;
        end else begin
            enc[0]   = {5'b11110, cp[20:18]};
            enc[1]   = {2'b10, cp[17:12]};
            enc[2]   = {2'b10, cp[11:6]};
            enc[3]   = {2'b10, cp[5:0]};
            enc_last = 2'd3;
        end
    end

    // character emitter
    assign adv  = r_job_valid && (!r_out_valid || m_axis_tready);
    assign cur  = r_bytes[r_byte_idx];
    assign kind = ufue_pkg::byte_kind(cur);

    always_comb begin
        case (kind)
            ufue_pkg::BYTE_PLUS: ch = ufue_pkg::CharPlus;
            ufue_pkg::BYTE_PASS: ch = cur[6:0];
            default: begin
                if (r_phase == 2'd0) begin
                    ch = ufue_pkg::CharPercent;
                end else if (r_phase == 2'd1) begin
                    ch = ufue_pkg::hex_digit(cur[7:4]);
                end else begin
                    ch = ufue_pkg::hex_digit(cur[3:0]);
                end
            end
        endcase
    end

    assign byte_done     = (kind != ufue_pkg::BYTE_PCT) || (r_phase == 2'd2);
    assign job_done      = byte_done && (r_byte_idx == r_last_idx);
    assign s_axis_tready = !r_job_valid || (adv && job_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_half    <= '0;
            r_high_pending <= 1'b0;
            r_halted       <= 1'b0;
            r_job_valid    <= 1'b0;
            r_byte_idx     <= '0;
            r_phase        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_high_half    <= n_high_half;
                r_high_pending <= n_high_pending;
                r_halted       <= n_halted;
            end

            if (in_acc && emit) begin
                r_job_valid <= 1'b1;
                r_byte_idx  <= '0;
                r_phase     <= '0;
            end else if (adv && job_done) begin
                r_job_valid <= 1'b0;
            end else if (adv) begin
                if (byte_done) begin
                    r_byte_idx <= r_byte_idx + 2'd1;
                    r_phase    <= '0;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end

            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && emit) begin
            r_bytes    <= enc;
            r_last_idx <= enc_last;
        end
        if (adv) begin
            r_out_char <= ch;
            r_out_last <= job_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_char};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire
